/* rtl/core/pgc_pkg.sv */
// Package for the prime-gcd pair counter: default sizes, port widths,
// controller state type and the command/status bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pgc_pkg;

  localparam int DEF_MAX_N      = 65536;
  localparam int DEF_MAX_PRIMES = 6542;
  localparam int BOUND_W        = 17;
  localparam int COUNT_W        = 33;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_I_RD, ST_I_CHK, ST_K_RD, ST_K_MUL, ST_K_WR,
    ST_P_RD, ST_P_ACC, ST_S_RD, ST_S_CHK, ST_S_DIV, ST_S_ADD, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic sieve_start;
    logic i_chk;
    logic k_mul;
    logic k_wr;
    logic i_inc;
    logic p_start;
    logic p_rd;
    logic p_acc;
    logic s_start;
    logic div_start;
    logic div_step;
    logic s_add;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic n_small;
    logic i_last;
    logic k_lt_pt;
    logic k_stop;
    logic j_last;
    logic p_gt_n;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/prime_gcd_pair_counter_unit.sv */
// Top level of the prime-gcd pair counter: joins controller and datapath.
// Depends on pgc_pkg, pgc_ctrl, pgc_dp (and pgc_ram through pgc_dp).
`timescale 1ns / 1ps
`default_nettype none
// Usage: present a bound on in_upper_bound and raise start while busy is low;
// the request is taken at that clock edge. The bound is saturated to 1..MAX_N.
// The block counts ordered pairs (x,y) in 1..n whose gcd is prime and shows
// the count on out_pair_count for exactly one cycle, marked by out_valid.
// Busy is high from the accepting edge until the result cycle, so
// the next request can be taken in the same cycle that the result is shown.
// One query runs four passes over block RAM, one access per port per cycle:
// a clearing pass of the least-factor store, the linear sieve (a check of
// each number, then a read, multiply and write for each composite it marks),
// the totient prefix pass and the summation, which runs a bit-serial divider
// for each prime up to n. A bound below 2 skips the sieve and prefix passes.
// Reset (synchronous, active low) returns the controller to idle and drops
// out_valid; store contents are not cleared since each query rebuilds them.
// The receiver cannot stall: out_valid drops after its one cycle.
module prime_gcd_pair_counter_unit #(
  parameter int MAX_N      = pgc_pkg::DEF_MAX_N,
  parameter int MAX_PRIMES = pgc_pkg::DEF_MAX_PRIMES
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [pgc_pkg::BOUND_W-1:0] in_upper_bound,
  output logic                             out_valid,
  output logic      [pgc_pkg::COUNT_W-1:0] out_pair_count
);
  import pgc_pkg::*;

  // Commands run from the controller to the datapath; status comes back.
  cmd_t cmd;
  sts_t sts;

  pgc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  pgc_dp #(.MAX_N(MAX_N), .MAX_PRIMES(MAX_PRIMES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_upper_bound(in_upper_bound),
    .sts(sts), .out_valid(out_valid), .out_pair_count(out_pair_count)
  );

endmodule
`default_nettype wire

/* rtl/core/pgc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/pgc_ctrl.sv */
// Controller of the prime-gcd pair counter: sequences clear, sieve, prefix
// and summation passes. Depends on pgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire pgc_pkg::sts_t sts,
  output pgc_pkg::cmd_t      cmd,
  output logic               busy
);
  import pgc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          if (sts.n_small) begin
            cmd.s_start = 1'b1;
            state_nxt   = ST_S_RD;
          end else begin
            cmd.sieve_start = 1'b1;
            state_nxt       = ST_I_RD;
          end
        end
      end
      ST_I_RD: state_nxt = ST_I_CHK;
      ST_I_CHK: begin
        cmd.i_chk = 1'b1;
        state_nxt = ST_K_RD;
      end
      ST_K_RD: begin
        if (sts.k_lt_pt) begin
          state_nxt = ST_K_MUL;
        end else begin
          cmd.i_inc = 1'b1;
          if (sts.i_last) begin
            cmd.p_start = 1'b1;
            state_nxt   = ST_P_RD;
          end else begin
            state_nxt = ST_I_RD;
          end
        end
      end
      ST_K_MUL: begin
        cmd.k_mul = 1'b1;
        state_nxt = ST_K_WR;
      end
      ST_K_WR: begin
        if (sts.k_stop) begin
          cmd.i_inc = 1'b1;
          if (sts.i_last) begin
            cmd.p_start = 1'b1;
            state_nxt   = ST_P_RD;
          end else begin
            state_nxt = ST_I_RD;
          end
        end else begin
          cmd.k_wr  = 1'b1;
          state_nxt = ST_K_RD;
        end
      end
      ST_P_RD: begin
        cmd.p_rd  = 1'b1;
        state_nxt = ST_P_ACC;
      end
      ST_P_ACC: begin
        cmd.p_acc = 1'b1;
        if (sts.j_last) begin
          cmd.s_start = 1'b1;
          state_nxt   = ST_S_RD;
        end else begin
          state_nxt = ST_P_RD;
        end
      end
      ST_S_RD: begin
        state_nxt = sts.k_lt_pt ? ST_S_CHK : ST_DONE;
      end
      ST_S_CHK: begin
        if (sts.p_gt_n) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_S_DIV;
        end
      end
      ST_S_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_S_ADD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_S_ADD: begin
        cmd.s_add = 1'b1;
        state_nxt = ST_S_RD;
      end
      ST_DONE: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

/* rtl/core/pgc_dp.sv */
// Datapath of the prime-gcd pair counter: counters, sieve stores, prefix
// store, divider and accumulator. Depends on pgc_pkg and pgc_ram.
`timescale 1ns / 1ps
`default_nettype none
module pgc_dp #(
  parameter int MAX_N      = pgc_pkg::DEF_MAX_N,
  parameter int MAX_PRIMES = pgc_pkg::DEF_MAX_PRIMES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pgc_pkg::cmd_t                 cmd,
  input  wire logic [pgc_pkg::BOUND_W-1:0]   in_upper_bound,
  output pgc_pkg::sts_t                      sts,
  output logic                               out_valid,
  output logic      [pgc_pkg::COUNT_W-1:0]   out_pair_count
);
  import pgc_pkg::*;

  localparam int NW = $clog2(MAX_N + 1);
  localparam int PW = $clog2(MAX_PRIMES + 1);
  localparam int KW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int FW = 2 * NW;
  localparam int TW = FW + 2;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r, clr_a_r, i_r, j_r;
  logic [PW-1:0] pt_r, k_r;
  logic [NW-1:0] cur_lf_r, cur_tot_r, p_r;
  logic [FW-1:0] prod_m_r, prod_t_r, acc_r;
  logic [TW-1:0] total_r;
  logic [NW-1:0] quo_r, rem_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  logic [COUNT_W-1:0] out_pair_count_r;

  logic [NW-1:0] lf_rd, tot_rd, pr_rd;
  logic [FW-1:0] pre_rd;
  logic          lf_we, tot_we, pr_we;
  logic [NW-1:0] lf_wa, lf_wd, tot_wa, tot_wd, tot_ra;
  logic          is_new, pt_full;
  logic [NW-1:0] factor;
  logic [FW-1:0] acc_sum;
  logic [NW:0]   trial;
  logic [NW-1:0] n_in;

  assign is_new  = (lf_rd == '0);
  assign pt_full = (pt_r == PW'(MAX_PRIMES));
  assign factor  = (pr_rd == cur_lf_r) ? pr_rd : pr_rd - NW'(1);
  assign acc_sum = acc_r + FW'(tot_rd);
  assign trial   = {rem_r, quo_r[NW-1]};
  assign n_in    = (32'(in_upper_bound) > MAX_N) ? NW'(MAX_N) :
                   ((in_upper_bound == '0) ? NW'(1) : NW'(in_upper_bound));

  always_comb begin
    lf_we = 1'b0;
    lf_wa = clr_a_r;
    lf_wd = '0;
    if (cmd.clr) begin
      lf_we = 1'b1;
    end else if (cmd.i_chk && is_new) begin
      lf_we = 1'b1;
      lf_wa = i_r;
      lf_wd = i_r;
    end else if (cmd.k_wr) begin
      lf_we = 1'b1;
      lf_wa = prod_m_r[NW-1:0];
      lf_wd = p_r;
    end
  end

  always_comb begin
    tot_we = 1'b0;
    tot_wa = NW'(1);
    tot_wd = NW'(1);
    if (cmd.sieve_start) begin
      tot_we = 1'b1;
    end else if (cmd.i_chk && is_new) begin
      tot_we = 1'b1;
      tot_wa = i_r;
      tot_wd = i_r - NW'(1);
    end else if (cmd.k_wr) begin
      tot_we = 1'b1;
      tot_wa = prod_m_r[NW-1:0];
      tot_wd = prod_t_r[NW-1:0];
    end
  end

  assign tot_ra = cmd.p_rd ? j_r : i_r;
  assign pr_we  = cmd.i_chk && is_new && !pt_full;

  pgc_ram #(.WIDTH(NW), .DEPTH(MAX_N + 1)) u_lf (
    .clk(clk), .we(lf_we), .waddr(lf_wa), .wdata(lf_wd), .raddr(i_r), .rdata(lf_rd)
  );
  pgc_ram #(.WIDTH(NW), .DEPTH(MAX_N + 1)) u_tot (
    .clk(clk), .we(tot_we), .waddr(tot_wa), .wdata(tot_wd), .raddr(tot_ra),
    .rdata(tot_rd)
  );
  pgc_ram #(.WIDTH(NW), .DEPTH(MAX_PRIMES)) u_pr (
    .clk(clk), .we(pr_we), .waddr(pt_r[KW-1:0]), .wdata(i_r), .raddr(k_r[KW-1:0]),
    .rdata(pr_rd)
  );
  pgc_ram #(.WIDTH(FW), .DEPTH(MAX_N + 1)) u_pre (
    .clk(clk), .we(cmd.p_acc), .waddr(j_r), .wdata(acc_sum), .raddr(quo_r),
    .rdata(pre_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r     <= n_in;
      clr_a_r <= '0;
    end else if (cmd.clr) begin
      clr_a_r <= clr_a_r + NW'(1);
    end
    if (cmd.sieve_start) begin
      i_r <= NW'(2);
    end else if (cmd.i_inc) begin
      i_r <= i_r + NW'(1);
    end
    if (cmd.i_chk) begin
      k_r       <= '0;
      cur_lf_r  <= is_new ? i_r : lf_rd;
      cur_tot_r <= is_new ? i_r - NW'(1) : tot_rd;
    end else if (cmd.k_wr || cmd.s_add) begin
      k_r <= k_r + PW'(1);
    end else if (cmd.s_start) begin
      k_r <= '0;
    end
    if (cmd.k_mul) begin
      p_r      <= pr_rd;
      prod_m_r <= FW'(i_r) * FW'(pr_rd);
      prod_t_r <= FW'(cur_tot_r) * FW'(factor);
    end
    if (cmd.p_start) begin
      j_r   <= NW'(1);
      acc_r <= '0;
    end else if (cmd.p_acc) begin
      j_r   <= j_r + NW'(1);
      acc_r <= acc_sum;
    end
    if (cmd.div_start) begin
      quo_r <= n_r;
      rem_r <= '0;
      dvs_r <= pr_rd;
      cnt_r <= CW'(NW);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - CW'(1);
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= NW'(trial - {1'b0, dvs_r});
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial[NW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.done) begin
      out_pair_count_r <= COUNT_W'(total_r);
    end
  end

  // Control state: prime count, running total, result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
      if (cmd.load) begin
        pt_r <= '0;
      end else if (pr_we) begin
        pt_r <= pt_r + PW'(1);
      end
      if (cmd.s_start) begin
        total_r <= '0;
      end else if (cmd.s_add) begin
        total_r <= total_r + {1'b0, pre_rd, 1'b0} - TW'(1);
      end
    end
  end

  assign sts.clr_last = (clr_a_r == n_r);
  assign sts.n_small  = (n_r < NW'(2));
  assign sts.i_last   = (i_r == n_r);
  assign sts.k_lt_pt  = (k_r < pt_r);
  assign sts.k_stop   = (p_r > cur_lf_r) || (prod_m_r > FW'(n_r));
  assign sts.j_last   = (j_r == n_r);
  assign sts.p_gt_n   = (pr_rd > n_r);
  assign sts.div_done = (cnt_r == '0);

  assign out_valid      = out_valid_r;
  assign out_pair_count = out_pair_count_r;

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.k_wr |-> (prod_m_r <= FW'(n_r)))
    else $error("sieve write beyond bound");
  a_pt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pt_r <= PW'(MAX_PRIMES))
    else $error("prime count overflow");
  a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (cnt_r != '0))
    else $error("divider stepped past its last bit");

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for prime_gcd_pair_counter_unit: it sends bounds,
// predicts the prime-gcd pair counts itself and checks every result.
// Depends on pgc_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_top;
  import pgc_pkg::*;

  localparam int LIMIT_N = DEF_MAX_N;
  // This limit leaves a wide margin over the longest query, that of a bound of 65536.
  localparam int STALL_LIMIT = 5000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [BOUND_W-1:0] in_upper_bound;
  logic               out_valid;
  logic [COUNT_W-1:0] out_pair_count;

  int errors = 0;
  int idle_cycles = 0;
  logic [COUNT_W-1:0] pending_counts[$];

  // Work arrays for the predictor. They are module-level because they are too large for the stack.
  int unsigned lpf[LIMIT_N+1];
  int unsigned phi[LIMIT_N+1];
  longint unsigned phi_sum[LIMIT_N+1];
  int unsigned primes[$];

  prime_gcd_pair_counter_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_upper_bound(in_upper_bound), .out_valid(out_valid),
    .out_pair_count(out_pair_count)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Count the pairs for one bound. The bound is clamped to 1..LIMIT_N first.
  // A linear sieve gives the totients. Each prime p then adds the number of
  // coprime ordered pairs up to n/p.
  function automatic logic [COUNT_W-1:0] prime_gcd_pairs(logic [BOUND_W-1:0] raw);
    int unsigned n;
    int unsigned p;
    int unsigned m;
    longint unsigned total;
    n = raw;
    if (n > LIMIT_N) n = LIMIT_N;
    if (n < 1) n = 1;
    foreach (lpf[j]) lpf[j] = 0;
    primes.delete();
    phi[1] = 1;
    for (int unsigned i = 2; i <= n; i++) begin
      if (lpf[i] == 0) begin
        lpf[i] = i;
        phi[i] = i - 1;
        primes.push_back(i);
      end
      foreach (primes[k]) begin
        p = primes[k];
        if (p > lpf[i] || p > n / i) break;
        m = i * p;
        lpf[m] = p;
        phi[m] = phi[i] * ((i % p) != 0 ? p - 1 : p);
      end
    end
    phi_sum[0] = 0;
    for (int unsigned i = 1; i <= n; i++) phi_sum[i] = phi_sum[i-1] + phi[i];
    total = 0;
    foreach (primes[k]) total += 2 * phi_sum[n / primes[k]] - 1;
    return total[COUNT_W-1:0];
  endfunction

  // Send one request after a gap of the given number of cycles. Start stays
  // high between back-to-back requests, so it is never lowered and raised
  // again within one time step.
  task automatic send_bound(logic [BOUND_W-1:0] bound, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_upper_bound <= bound;
    do @(posedge clk); while (busy);
    pending_counts.push_back(prime_gcd_pairs(bound));
  endtask

  task automatic send_random_gap(logic [BOUND_W-1:0] bound);
    send_bound(bound, $urandom_range(0, 5));
  endtask

  task automatic wait_all_results();
    @(posedge clk);
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
  endtask

  // Checker: the receiver cannot stall, so every strobe is taken at once.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_counts.size() == 0) begin
        $error("pair_count: unexpected result %0d", out_pair_count);
        errors++;
      end else begin
        if (out_pair_count !== pending_counts[0]) begin
          $error("pair_count: expected %0d, actual %0d", pending_counts[0], out_pair_count);
          errors++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  // Watchdog: it counts the cycles in which no request and no result is taken.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Special cases: bounds of zero and one, the smallest primes, and the bounds 4, 10, 100, 1365 and 2730.
  // The bounds 0 and 1 give no pairs.
  task automatic test_small_bounds();
    send_bound(0, 0);
    send_bound(1, 0);
    send_bound(2, 0);
    send_bound(3, 1);
    send_bound(4, 3);
    send_bound(5, 0);
    send_bound(10, 2);
    send_bound(100, 0);
    send_bound(17'h0AAAA >> 4, 1);
    send_bound(17'h05555 >> 4, 4);
  endtask

  // The upper extreme, and an oversized bound that saturates to the maximum.
  // The all-ones bound also sets bit 16.
  task automatic test_large_bounds();
    send_bound(17'(LIMIT_N), 2);
    send_bound(17'h1FFFF, 0);
  endtask

  // The sender holds off until the unit has drained, then restarts.
  task automatic test_drain_pause();
    send_bound(30, 0);
    wait_all_results();
    send_bound(31, 0);
    wait_all_results();
  endtask

  // Most bounds are small to keep the run short. A few reach a few thousand,
  // and the gaps vary, with back-to-back stretches.
  task automatic test_random_bounds();
    for (int it = 0; it < 100; it++) begin
      if (it >= 40 && it < 55) send_bound($urandom_range(0, 300), 0);
      else if ($urandom_range(0, 9) == 0) send_random_gap($urandom_range(301, 4000));
      else send_random_gap($urandom_range(0, 300));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_upper_bound = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_bounds();
    test_drain_pause();
    test_large_bounds();
    test_random_bounds();
    wait_all_results();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
